// File: rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// shared types, codes and widths of the double-ended queue
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned CMD_W         = 2;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned FILL_W        = 5;
  localparam int unsigned DEFAULT_DEPTH = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_POP_FRONT  = 2'd1,
    CMD_PUSH_REAR  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic wr;        // accepted push that fits
    logic rd;        // accepted pop with data present
    logic load_now;  // result known at accept
    logic load_rd;   // result from the read data
  } dq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } dq_stat_t;

endpackage

// File: rtl/dq_if.sv
// ----------------------------------------------------------------------------
// dq_in_if / dq_out_if
// valid/ready channels carrying queue operations and their results
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                             valid;
  logic                             ready;
  logic        [dq_pkg::CMD_W-1:0]  command;
  logic signed [dq_pkg::WORD_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface dq_out_if;
  logic                               valid;
  logic                               ready;
  logic        [dq_pkg::STATUS_W-1:0] status;
  logic signed [dq_pkg::WORD_W-1:0]   popped_word;
  logic        [dq_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output status, output popped_word, output fill_count,
                  input ready);
  modport sink   (input valid, input status, input popped_word, input fill_count,
                  output ready);
endinterface

// File: rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded double-ended queue of signed 32-bit words in a circular buffer
// ----------------------------------------------------------------------------
// Each transaction on in_i carries a command (push front, pop front, push
// rear, pop rear) and a value; each gives exactly one result on out_o with
// status, popped word and fill count. Words sit in a DEPTH-entry RAM with a
// registered read port. For a push, or any operation that overflows or
// underflows, the result is registered at the accepting edge, so one such
// transaction per cycle is sustained while out_o is drained. A successful pop
// reads the RAM at the accepting edge and the read data is loaded into the
// result register from S_READ; no new transaction is taken until S_IDLE. A
// new transaction is taken while a result is pending if out_o is being
// drained in the same cycle. fill_count shows the low 5 bits of the count.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned DEPTH = dq_pkg::DEFAULT_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  dq_in_if.sink   in_i,
  dq_out_if.source out_o
);
  import dq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .command_i   (in_i.command),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (in_i.command),
    .value_i       (in_i.value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (out_o.status),
    .popped_word_o (out_o.popped_word),
    .fill_count_o  (out_o.fill_count)
  );

endmodule

// File: rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/dq_ctrl.sv
// ----------------------------------------------------------------------------
// dq_ctrl
// handshake control: accepts operations, sequences pop reads, owns result valid
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [dq_pkg::CMD_W-1:0] command_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dq_pkg::dq_stat_t     stat_i,
  output dq_pkg::dq_cmd_t      cmd_o
);
  import dq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   is_push;
  logic   pop_ok;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign is_push    = (cmd_e'(command_i) == CMD_PUSH_FRONT) ||
                      (cmd_e'(command_i) == CMD_PUSH_REAR);
  assign pop_ok     = !is_push && !stat_i.empty;

  assign cmd_o.wr       = accept && is_push && !stat_i.full;
  assign cmd_o.rd       = accept && pop_ok;
  assign cmd_o.load_now = accept && !pop_ok;
  assign cmd_o.load_rd  = (state_q == S_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && pop_ok) begin
            state_q <= S_READ;
          end
          if (accept && !pop_ok) begin
            out_valid_q <= 1'b1;
          end else if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_READ: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/dq_dp.sv
// ----------------------------------------------------------------------------
// dq_dp
// pointers, fill count, word store and result register of the queue
// ----------------------------------------------------------------------------
module dq_dp #(
  parameter int unsigned DEPTH = dq_pkg::DEFAULT_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic        [dq_pkg::CMD_W-1:0]    command_i,
  input  logic signed [dq_pkg::WORD_W-1:0]   value_i,
  input  dq_pkg::dq_cmd_t                    cmd_i,
  output dq_pkg::dq_stat_t                   stat_o,
  output logic        [dq_pkg::STATUS_W-1:0] status_o,
  output logic signed [dq_pkg::WORD_W-1:0]   popped_word_o,
  output logic        [dq_pkg::FILL_W-1:0]   fill_count_o
);
  import dq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] count_q, count_d;
  logic [PW-1:0] head_up, head_dn, tail_up, tail_dn;
  logic          front;
  logic          is_push;
  logic [PW-1:0] waddr, raddr;
  logic [WORD_W-1:0] rdata;

  logic [STATUS_W-1:0]      status_q;
  logic signed [WORD_W-1:0] popped_q;
  logic [FILL_W-1:0]        fill_q;

  assign head_up = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
  assign head_dn = (head_q == '0) ? PW'(DEPTH - 1) : head_q - PW'(1);
  assign tail_up = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
  assign tail_dn = (tail_q == '0) ? PW'(DEPTH - 1) : tail_q - PW'(1);

  always_comb begin
    front   = 1'b0;
    is_push = 1'b0;
    unique case (cmd_e'(command_i))
      CMD_PUSH_FRONT: begin
        front   = 1'b1;
        is_push = 1'b1;
      end
      CMD_POP_FRONT: begin
        front = 1'b1;
      end
      CMD_PUSH_REAR: begin
        is_push = 1'b1;
      end
      CMD_POP_REAR: begin
        front = 1'b0;
      end
      default: begin
        front = 1'b0;
      end
    endcase
  end

  assign stat_o.full  = (count_q == CW'(DEPTH));
  assign stat_o.empty = (count_q == '0);

  assign waddr = front ? head_dn : tail_q;
  assign raddr = front ? head_q : tail_dn;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (cmd_i.wr) begin
      count_d = count_q + CW'(1);
      if (front) begin
        head_d = head_dn;
      end else begin
        tail_d = tail_up;
      end
    end else if (cmd_i.rd) begin
      count_d = count_q - CW'(1);
      if (front) begin
        head_d = head_up;
      end else begin
        tail_d = tail_dn;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  dq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (waddr),
    .wdata_i (value_i),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      if (cmd_i.wr) begin
        status_q <= ST_DONE;
      end else if (is_push) begin
        status_q <= ST_OVERFLOW;
      end else begin
        status_q <= ST_UNDERFLOW;
      end
      popped_q <= '0;
      fill_q   <= FILL_W'(count_d);
    end else if (cmd_i.load_rd) begin
      status_q <= ST_DONE;
      popped_q <= rdata;
      fill_q   <= FILL_W'(count_q);
    end
  end

  assign status_o      = status_q;
  assign popped_word_o = popped_q;
  assign fill_count_o  = fill_q;

endmodule

// File: rtl/dq_checker.sv
// ----------------------------------------------------------------------------
// dq_port_checks
// port-level checks of the double-ended queue, bound to the top level
// ----------------------------------------------------------------------------
module dq_port_checks #(
  parameter int unsigned DEPTH = dq_pkg::DEFAULT_DEPTH
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [dq_pkg::STATUS_W-1:0]   status_i,
  input logic [dq_pkg::WORD_W-1:0]     popped_word_i,
  input logic [dq_pkg::FILL_W-1:0]     fill_count_i
);
  import dq_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(status_i) && $stable(popped_word_i) && $stable(fill_count_i))
    else $error("result changed while stalled");

  // no new transaction while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while result stalled");

  // every rise of result valid follows an accepted transaction
  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_acc) || $past(in_acc, 2))
    else $error("result without transaction");

  // overflow only when full
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OVERFLOW) |-> fill_count_i == FILL_W'(DEPTH))
    else $error("overflow while not full");

  // underflow only when empty, and returns zero
  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_UNDERFLOW) |->
      (fill_count_i == '0) && (popped_word_i == '0))
    else $error("bad underflow result");

endmodule

bind double_ended_queue dq_port_checks #(
  .DEPTH (DEPTH)
) u_dq_port_checks (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .popped_word_i (out_o.popped_word),
  .fill_count_i  (out_o.fill_count)
);

// File: verif/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// watches both channels of the double-ended queue and checks every result
// ----------------------------------------------------------------------------
// Keeps its own circular-buffer model of the queue. Each accepted operation
// is applied to the model and the result it must give is queued; each
// accepted result is compared field by field with the oldest queued one.
// Passes the mismatch count and the number of outstanding results upwards.
// ----------------------------------------------------------------------------
module dq_checker #(
  parameter int unsigned DEPTH = dq_pkg::DEFAULT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_in_if            in_mon_i,
  dq_out_if           out_mon_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);
  import dq_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    status_e                  status;
    logic signed [WORD_W-1:0] word;
    logic        [FILL_W-1:0] fill;
  } deque_result_t;

  logic signed [WORD_W-1:0] model_words [DEPTH];
  int unsigned              front_idx;
  int unsigned              rear_idx;
  int unsigned              held_words;
  int unsigned              mismatches;
  deque_result_t            awaited_results [$];

  function automatic deque_result_t predict_deque_op(input cmd_e cmd,
                                                     input logic signed [WORD_W-1:0] val);
    deque_result_t res;
    res.status = ST_DONE;
    res.word   = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (held_words >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          front_idx              = (front_idx + DEPTH - 1) % DEPTH;
          model_words[front_idx] = val;
          held_words++;
        end
      end
      CMD_PUSH_REAR: begin
        if (held_words >= DEPTH) begin
          res.status = ST_OVERFLOW;
        end else begin
          model_words[rear_idx] = val;
          rear_idx              = (rear_idx + 1) % DEPTH;
          held_words++;
        end
      end
      CMD_POP_FRONT: begin
        if (held_words == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          res.word  = model_words[front_idx];
          front_idx = (front_idx + 1) % DEPTH;
          held_words--;
        end
      end
      CMD_POP_REAR: begin
        if (held_words == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
          res.word = model_words[rear_idx];
          held_words--;
        end
      end
    endcase
    res.fill = FILL_W'(held_words);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      front_idx  = 0;
      rear_idx   = 0;
      held_words = 0;
      mismatches = 0;
      awaited_results.delete();
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
    end else begin
      // results first: a result never belongs to an operation taken at the same edge
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t dq_checker: unexpected result status %0d word %0d fill %0d",
                     $realtime, out_mon_i.status, out_mon_i.popped_word,
                     out_mon_i.fill_count);
          end
        end else begin
          want = awaited_results.pop_front();
          if (out_mon_i.status !== want.status || out_mon_i.popped_word !== want.word ||
              out_mon_i.fill_count !== want.fill) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t dq_checker: mismatch expected status %0d word %0d fill %0d",
                       $realtime, want.status, want.word, want.fill);
              $display("%0t dq_checker:          actual   status %0d word %0d fill %0d",
                       $realtime, out_mon_i.status, out_mon_i.popped_word,
                       out_mon_i.fill_count);
            end
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        awaited_results.push_back(predict_deque_op(cmd_e'(in_mon_i.command), in_mon_i.value));
      end
      mismatch_count_o <= mismatches;
      pending_count_o  <= awaited_results.size();
    end
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the double-ended queue
// ----------------------------------------------------------------------------
// A short directed run covers underflow on both ends, the extreme words,
// filling to capacity and overflow on both ends. Random operations follow in
// runs biased towards pushes or pops so the queue swings between empty and
// full, under three idling patterns on the two channels. A long receiver
// hold-off early in the random part backs the queue up. Results are checked
// by dq_checker; a watchdog ends the run if transactions stop.
// ----------------------------------------------------------------------------
module testbench;
  import dq_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned RANDOM_ITEMS   = 633;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 0;
  int          stim_phase   = 0;

  dq_in_if  in_if ();
  dq_out_if out_if ();

  double_ended_queue #(
    .DEPTH (DEFAULT_DEPTH)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dq_checker #(
    .DEPTH (DEFAULT_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_mon_i         (in_if),
    .out_mon_i        (out_if),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // receiver side
  initial begin : result_drain
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stim_phase == 1 && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (!rst_ni) begin
        out_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (stim_phase)
          1:       out_if.ready <= ($urandom_range(99) >= 46);
          2:       out_if.ready <= ($urandom_range(99) >= 15);
          default: out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_op(input cmd_e cmd, input logic signed [WORD_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.value   <= val;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_random_ops(input int unsigned count);
    int unsigned              push_pct;
    bit                       push;
    bit                       front;
    cmd_e                     cmd;
    logic signed [WORD_W-1:0] val;
    push_pct = 50;
    for (int unsigned n = 0; n < count; n++) begin
      // runs leaning towards pushes, towards pops or balanced, so both full and empty are reached
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 15;
          1:       push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      push  = ($urandom_range(99) < push_pct);
      front = $urandom_range(1);
      if (push) begin
        cmd = front ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
      end else begin
        cmd = front ? CMD_POP_FRONT : CMD_POP_REAR;
      end
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7fff_ffff;
          2:       val = '0;
          default: val = '1;
        endcase
      end else begin
        val = $urandom;
      end
      send_op(cmd, val);
    end
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.command <= CMD_PUSH_FRONT;
    in_if.value   <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue, extreme words, wrap of the front index
    send_op(CMD_POP_FRONT, 32'h1234_5678);
    send_op(CMD_POP_REAR, '1);
    send_op(CMD_PUSH_FRONT, 32'h8000_0000);
    send_op(CMD_PUSH_REAR, 32'h7fff_ffff);
    send_op(CMD_PUSH_FRONT, '1);
    send_op(CMD_PUSH_REAR, '0);
    send_op(CMD_POP_REAR, '0);
    send_op(CMD_POP_FRONT, '1);
    // fill to capacity, then overflow on both ends
    for (int unsigned n = 0; n < DEFAULT_DEPTH - 2; n++) begin
      send_op((n % 2 == 0) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, $urandom);
    end
    send_op(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_op(CMD_PUSH_REAR, 32'h8000_0000);

    stim_phase  <= 1;
    tx_idle_pct  = 15;
    send_random_ops(RANDOM_ITEMS);
    stim_phase  <= 2;
    tx_idle_pct  = 46;
    send_random_ops(RANDOM_ITEMS);
    stim_phase  <= 3;
    tx_idle_pct  = 0;
    send_random_ops(RANDOM_ITEMS + 1);
    in_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
